### src/led_linear_fade_controller_macros.svh
// assertion macros for the led linear fade controller checker
// no dependencies
`ifndef LED_LINEAR_FADE_CONTROLLER_MACROS_SVH
`define LED_LINEAR_FADE_CONTROLLER_MACROS_SVH

// antecedent holds, consequent checked from the same cycle
`define LFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("lfc assertion failed");

// antecedent holds, consequent checked in the next cycle
`define LFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfc assertion failed");

`endif

### src/lfc_pkg.sv
// shared types and constants of the led linear fade controller
// no dependencies
`timescale 1ns / 1ps

package lfc_pkg;

  localparam int TimeBitsDef = 16;

  localparam int LvlW  = 7;
  localparam int DurW  = 16;
  localparam int KindW = 3;
  localparam int DataW = 32;
  localparam int AddrW = 4;
  localparam int QuoW  = 7;
  localparam int ProdW = DurW + LvlW;
  localparam int StepW = 3;

  localparam logic [KindW-1:0] KindTick   = 3'd0;
  localparam logic [KindW-1:0] KindFade   = 3'd1;
  localparam logic [KindW-1:0] KindSet    = 3'd2;
  localparam logic [KindW-1:0] KindOn     = 3'd3;
  localparam logic [KindW-1:0] KindOff    = 3'd4;
  localparam logic [KindW-1:0] KindToggle = 3'd5;

  localparam logic [1:0] RegMin = 2'd0;
  localparam logic [1:0] RegMax = 2'd1;
  localparam logic [1:0] RegDur = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic mul;
    logic div;
    logic wb;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

### src/lfc_ctrl.sv
// controller state machine of the led linear fade controller
// depends on lfc_pkg
`timescale 1ns / 1ps

module lfc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lfc_pkg::sts_t sts_i,
  output lfc_pkg::cmd_t cmd_o
);
  import lfc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_WB   = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_div ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

### src/lfc_datapath.sv
// datapath of the led linear fade controller: level state, multiplier,
// seven-step restoring divider and output register; depends on lfc_pkg
`timescale 1ns / 1ps

module lfc_datapath #(
  parameter int TIME_BITS = lfc_pkg::TimeBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lfc_pkg::cmd_t              cmd_i,
  output lfc_pkg::sts_t              sts_o,
  input  logic [lfc_pkg::KindW-1:0]  kind_i,
  input  logic [lfc_pkg::LvlW-1:0]   value_i,
  input  logic [lfc_pkg::LvlW-1:0]   min_i,
  input  logic [lfc_pkg::LvlW-1:0]   max_i,
  input  logic [lfc_pkg::DurW-1:0]   dur_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [lfc_pkg::LvlW-1:0]   out_level_o,
  output logic                       out_is_on_o,
  output logic                       out_is_off_o,
  output logic                       out_fading_o
);
  import lfc_pkg::*;

  localparam int CmpW = (TIME_BITS > DurW) ? TIME_BITS : DurW;
  localparam logic [TIME_BITS-1:0] TimeTop = {TIME_BITS{1'b1}};

  logic [KindW-1:0]     kind_q;
  logic [LvlW-1:0]      value_q;
  logic [LvlW-1:0]      level_q, level_d;
  logic [LvlW-1:0]      start_q, start_d;
  logic [LvlW-1:0]      target_q, target_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic [ProdW-1:0]     rem_q, rem_d;
  logic [QuoW-1:0]      quo_q, quo_d;
  logic [StepW-1:0]     step_q, step_d;
  logic                 neg_q, neg_d;
  logic                 out_valid_q, out_valid_d;
  logic [LvlW-1:0]      out_level_q;
  logic                 out_is_on_q, out_is_off_q, out_fading_q;

  logic [TIME_BITS-1:0] el_inc;
  logic [CmpW-1:0]      el_ext;
  logic [CmpW-1:0]      dur_ext;
  logic                 fade_req;
  logic [LvlW-1:0]      fade_goal;
  logic [LvlW-1:0]      clamped;
  logic [LvlW:0]        span;
  logic [LvlW-1:0]      mag;
  logic [ProdW-1:0]     trial;

  // elapsed time for a tick, saturating
  assign el_inc  = (elapsed_q == TimeTop) ? elapsed_q : elapsed_q + 1'b1;
  assign el_ext  = CmpW'(elapsed_q);
  assign dur_ext = CmpW'(dur_i);

  assign sts_o.need_div = (kind_q == KindTick) && (level_q != target_q) &&
                          (dur_i != '0) && (CmpW'(el_inc) < dur_ext);
  assign sts_o.div_last = (step_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // goal of a fade command
  always_comb begin
    fade_req  = 1'b0;
    fade_goal = value_q;
    unique case (kind_q)
      KindFade: begin
        fade_req  = 1'b1;
        fade_goal = value_q;
      end
      KindOn: begin
        fade_req  = 1'b1;
        fade_goal = max_i;
      end
      KindOff: begin
        fade_req  = 1'b1;
        fade_goal = min_i;
      end
      KindToggle: begin
        priority if (level_q == max_i) begin
          fade_req  = 1'b1;
          fade_goal = min_i;
        end else if (level_q == min_i) begin
          fade_req  = 1'b1;
          fade_goal = max_i;
        end else begin
          fade_req = 1'b0;
        end
      end
      default: begin
        fade_req = 1'b0;
      end
    endcase
  end

  always_comb begin
    priority if (value_q < min_i) begin
      clamped = min_i;
    end else if (value_q > max_i) begin
      clamped = max_i;
    end else begin
      clamped = value_q;
    end
  end

  assign span  = {1'b0, target_q} - {1'b0, start_q};
  assign mag   = span[LvlW] ? LvlW'(-span) : span[LvlW-1:0];
  assign trial = ProdW'(dur_i) << step_q;

  always_comb begin
    level_d   = level_q;
    start_d   = start_q;
    target_d  = target_q;
    elapsed_d = elapsed_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    step_d    = step_q;
    neg_d     = neg_q;
    if (cmd_i.exec) begin
      if (kind_q == KindTick) begin
        elapsed_d = el_inc;
        if ((level_q != target_q) && !sts_o.need_div) begin
          level_d = target_q;
        end
      end else if (kind_q == KindSet) begin
        level_d  = clamped;
        target_d = clamped;
      end else if (fade_req) begin
        if (dur_i != '0) begin
          start_d   = level_q;
          target_d  = fade_goal;
          elapsed_d = '0;
        end else begin
          level_d  = fade_goal;
          target_d = fade_goal;
        end
      end
    end
    if (cmd_i.mul) begin
      rem_d  = ProdW'(el_ext[DurW-1:0]) * ProdW'(mag);
      quo_d  = '0;
      step_d = StepW'(QuoW - 1);
      neg_d  = span[LvlW];
    end
    if (cmd_i.div) begin
      if (rem_q >= trial) begin
        rem_d         = rem_q - trial;
        quo_d[step_q] = 1'b1;
      end
      step_d = step_q - 1'b1;
    end
    if (cmd_i.wb) begin
      level_d = neg_q ? start_q - quo_q : start_q + quo_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      start_q     <= '0;
      target_q    <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      level_q     <= level_d;
      start_q     <= start_d;
      target_q    <= target_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    neg_q  <= neg_d;
    if (cmd_i.out_load) begin
      out_level_q  <= level_q;
      out_is_on_q  <= (level_q == max_i);
      out_is_off_q <= (level_q == min_i);
      out_fading_q <= (level_q != target_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_level_o  = out_level_q;
  assign out_is_on_o  = out_is_on_q;
  assign out_is_off_o = out_is_off_q;
  assign out_fading_o = out_fading_q;

endmodule

### src/led_linear_fade_controller.sv
// top level of the led linear fade controller: register port, controller
// and datapath; depends on lfc_pkg, lfc_ctrl and lfc_datapath
//
//   channel  direction  handshake              words
//   in       sink       in_valid_i/in_stall_o  kind, value
//   out      source     out_valid_o/out_stall_i level, is_on, is_off, fading
//   cfg      apb slave  psel/penable/pready    min, max, duration
//
// a tick that moves the level mid-fade passes exec, mul, the seven-step divider loop,
// wb and out from acceptance to result; every other word passes exec and out
// one word is in work at a time; the next is taken while a result waits
// reset is asynchronous and active low; no memory to clear
// a stalled output holds the finished word until it is taken
`timescale 1ns / 1ps

module led_linear_fade_controller #(
  parameter int TIME_BITS = lfc_pkg::TimeBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lfc_pkg::KindW-1:0]  in_kind_i,
  input  logic [lfc_pkg::LvlW-1:0]   in_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lfc_pkg::LvlW-1:0]   out_level_o,
  output logic                       out_is_on_o,
  output logic                       out_is_off_o,
  output logic                       out_fading_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lfc_pkg::AddrW-1:0]  paddr,
  input  logic [lfc_pkg::DataW-1:0]  pwdata,
  output logic [lfc_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import lfc_pkg::*;

  logic [LvlW-1:0] min_q;
  logic [LvlW-1:0] max_q;
  logic [DurW-1:0] dur_q;
  logic            wr_en;
  cmd_t            cmd;
  sts_t            sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= LvlW'(100);
      dur_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegMin:  min_q <= pwdata[LvlW-1:0];
        RegMax:  max_q <= pwdata[LvlW-1:0];
        RegDur:  dur_q <= pwdata[DurW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegMin:  prdata = DataW'(min_q);
      RegMax:  prdata = DataW'(max_q);
      RegDur:  prdata = DataW'(dur_q);
      default: prdata = '0;
    endcase
  end

  lfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfc_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (in_kind_i),
    .value_i      (in_value_i),
    .min_i        (min_q),
    .max_i        (max_q),
    .dur_i        (dur_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_level_o  (out_level_o),
    .out_is_on_o  (out_is_on_o),
    .out_is_off_o (out_is_off_o),
    .out_fading_o (out_fading_o)
  );

endmodule

### src/lfc_checker.sv
// port-level checks of the led linear fade controller, bound to the top
// depends on lfc_pkg and led_linear_fade_controller_macros.svh
`timescale 1ns / 1ps
`include "led_linear_fade_controller_macros.svh"

module lfc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [lfc_pkg::KindW-1:0] in_kind_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [lfc_pkg::LvlW-1:0]  out_level_o
);
  import lfc_pkg::*;

  logic in_acc;
  logic cmd_acc;
  logic out_held;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign cmd_acc  = in_acc && (in_kind_i != KindTick) && !out_valid_o;
  assign out_held = out_valid_o && out_stall_i;

  // one word in work at a time
  `LFC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o)

  // a command word taken with a free output passes exec and out, then gives its result
  `LFC_ASSERT_IMPL(a_cmd_latency, clk_i, rst_ni, cmd_acc, ##3 out_valid_o)

  `LFC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_level_o))

endmodule

bind led_linear_fade_controller lfc_checker u_lfc_checker (.*);
